FILE: src/wsp_pkg.sv
// Package: shared types and codes for the stereo WAVE stream parser.
`timescale 1ns / 1ps
package wsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } wsp_in_t;

  typedef struct packed {
    logic [31:0] left_sample;
    logic [31:0] right_sample;
    logic        frame_valid;
    logic [2:0]  status;
    logic        finished;
  } wsp_out_t;

  // Raw frame handed from the parser to the sample converter.
  typedef struct packed {
    logic        frame_valid;
    logic [2:0]  status;
    logic        finished;
    logic        is_pcm;
    logic        is_single;
    logic [63:0] left_raw;
    logic [63:0] right_raw;
  } wsp_item_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_ALIGN     = 3'd3;
  localparam logic [2:0] ST_COMPRESS  = 3'd4;
  localparam logic [2:0] ST_CHANNELS  = 3'd5;
  localparam logic [2:0] ST_BITS      = 3'd6;
  localparam logic [2:0] ST_EOF       = 3'd7;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] TAG_PCM   = 16'd1;
  localparam logic [15:0] TAG_FLOAT = 16'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

endpackage

FILE: src/wsp_parser.sv
// Chunk walker: header checks, fmt capture, skipping and frame byte capture.
`timescale 1ns / 1ps
module wsp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              in_valid,
  input  wsp_pkg::wsp_in_t  in_beat,
  output logic              item_valid_r,
  output wsp_pkg::wsp_item_t item_r
);
  import wsp_pkg::*;

  typedef enum logic [7:0] {
    PH_RIFF   = 8'b0000_0001,
    PH_FSIZE  = 8'b0000_0010,
    PH_WAVE   = 8'b0000_0100,
    PH_CKID   = 8'b0000_1000,
    PH_CKSIZE = 8'b0001_0000,
    PH_FMT    = 8'b0010_0000,
    PH_SKIP   = 8'b0100_0000,
    PH_DATA   = 8'b1000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        pad_r, pad_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [63:0] lcap_r, lcap_nxt;
  logic [63:0] rcap_r, rcap_nxt;
  logic        stop_r, stop_nxt;
  logic        item_valid_nxt;
  wsp_item_t   item_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        word_done;
  logic        fin, fv;
  logic [2:0]  st;
  logic [28:0] expect_bytes;
  logic [3:0]  bps;
  logic [2:0]  lidx, ridx;
  logic [15:0] loff, roff, lrel, rrel;

  assign accept = in_valid && advance && !stop_r;
  assign b      = in_beat.data_byte;

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    kind_nxt  = kind_r;
    pad_nxt   = pad_r;
    tag_nxt   = tag_r;
    ch_nxt    = ch_r;
    align_nxt = align_r;
    bits_nxt  = bits_r;
    idx_nxt   = idx_r;
    lcap_nxt  = lcap_r;
    rcap_nxt  = rcap_r;
    stop_nxt  = stop_r;
    fin       = 1'b0;
    fv        = 1'b0;
    st        = ST_OK;
    word_done = 1'b0;
    expect_bytes = '0;
    bps  = bits_r[6:3];
    lidx = 3'd0;
    ridx = 3'd1;
    case (ch_r)
      16'd1: begin lidx = 3'd0; ridx = 3'd0; end
      16'd4: begin lidx = 3'd0; ridx = 3'd2; end
      16'd6: begin lidx = 3'd1; ridx = 3'd4; end
      default: begin lidx = 3'd0; ridx = 3'd1; end
    endcase
    loff = 16'(lidx * 7'(bps));
    roff = 16'(ridx * 7'(bps));
    lrel = idx_r - loff;
    rrel = idx_r - roff;

    // Gather header words little-endian.
    if ((phase_r == PH_RIFF) || (phase_r == PH_FSIZE) || (phase_r == PH_WAVE) ||
        (phase_r == PH_CKID) || (phase_r == PH_CKSIZE)) begin
      shift_nxt = {b, shift_r[31:8]};
      cnt_nxt   = cnt_r + 2'd1;
      word_done = (cnt_r == 2'd3);
    end

    case (phase_r)
      PH_RIFF: begin
        if (word_done) begin
          if (shift_nxt != ID_RIFF) begin fin = 1'b1; st = ST_NOT_RIFF; end
          else phase_nxt = PH_FSIZE;
        end
      end
      PH_FSIZE: begin
        if (word_done) phase_nxt = PH_WAVE;
      end
      PH_WAVE: begin
        if (word_done) begin
          if (shift_nxt != ID_WAVE) begin fin = 1'b1; st = ST_NOT_WAVE; end
          else phase_nxt = PH_CKID;
        end
      end
      PH_CKID: begin
        if (word_done) begin
          kind_nxt  = (shift_nxt == ID_FMT)  ? KIND_FMT :
                      (shift_nxt == ID_DATA) ? KIND_DATA : KIND_OTHER;
          phase_nxt = PH_CKSIZE;
        end
      end
      PH_CKSIZE: begin
        if (word_done) begin
          rem_nxt = shift_nxt;
          if (kind_r == KIND_FMT) begin
            idx_nxt   = '0;
            phase_nxt = PH_FMT;
          end else if (kind_r == KIND_DATA) begin
            if (tag_r == TAG_PCM)
              st = (bits_r == 16'd16) ? ST_OK : ST_BITS;
            else if (tag_r == TAG_FLOAT)
              st = ((bits_r == 16'd32) || (bits_r == 16'd64)) ? ST_OK : ST_BITS;
            else
              st = ST_COMPRESS;
            if ((st != ST_OK) || (shift_nxt == '0)) begin
              fin = 1'b1;
            end else begin
              idx_nxt   = '0;
              lcap_nxt  = '0;
              rcap_nxt  = '0;
              phase_nxt = PH_DATA;
            end
          end else begin
            pad_nxt   = shift_nxt[0];
            phase_nxt = (shift_nxt == '0) ? PH_CKID : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        case (idx_r)
          16'd0:  tag_nxt   = {8'd0, b};
          16'd1:  tag_nxt   = {b, tag_r[7:0]};
          16'd2:  ch_nxt    = {8'd0, b};
          16'd3:  ch_nxt    = {b, ch_r[7:0]};
          16'd12: align_nxt = {8'd0, b};
          16'd13: align_nxt = {b, align_r[7:0]};
          16'd14: bits_nxt  = {8'd0, b};
          16'd15: bits_nxt  = {b, bits_r[7:0]};
          default: ;
        endcase
        idx_nxt = idx_r + 16'd1;
        if (idx_r == 16'd15) begin
          idx_nxt      = '0;
          expect_bytes = 29'(ch_nxt) * 29'(bits_nxt[15:3]);
          if (29'(align_nxt) != expect_bytes)
            st = ST_ALIGN;
          else if ((tag_nxt != TAG_PCM) && (tag_nxt != TAG_FLOAT))
            st = ST_COMPRESS;
          else if ((ch_nxt == 16'd0) || (ch_nxt == 16'd5) || (ch_nxt > 16'd6))
            st = ST_CHANNELS;
          if (st != ST_OK) begin
            fin = 1'b1;
          end else if (rem_r > 32'd16) begin
            rem_nxt   = rem_r - 32'd16;
            pad_nxt   = rem_r[0];
            phase_nxt = PH_SKIP;
          end else begin
            rem_nxt   = '0;
            pad_nxt   = 1'b0;
            phase_nxt = PH_CKID;
          end
        end
      end
      PH_SKIP: begin
        if (rem_r != '0) rem_nxt = rem_r - 32'd1;
        else pad_nxt = 1'b0;
        if ((rem_nxt == '0) && !pad_nxt) phase_nxt = PH_CKID;
      end
      PH_DATA: begin
        if ((idx_r >= loff) && (lrel < 16'(bps)) && (lrel < 16'd8))
          lcap_nxt = lcap_r | ({56'd0, b} << {lrel[2:0], 3'b000});
        if ((idx_r >= roff) && (rrel < 16'(bps)) && (rrel < 16'd8))
          rcap_nxt = rcap_r | ({56'd0, b} << {rrel[2:0], 3'b000});
        idx_nxt = idx_r + 16'd1;
        rem_nxt = rem_r - 32'd1;
        if (idx_nxt >= align_r) begin
          fv = 1'b1;
          idx_nxt = '0;
        end
        if (rem_nxt == '0) fin = 1'b1;
      end
      default: begin
        fin = 1'b1;
        st  = ST_EOF;
      end
    endcase

    if (!fin && in_beat.end_of_file) begin
      fin = 1'b1;
      st  = ST_EOF;
    end
    if (fin) stop_nxt = 1'b1;

    item_nxt.frame_valid = fv;
    item_nxt.status      = st;
    item_nxt.finished    = fin;
    item_nxt.is_pcm      = (tag_r == TAG_PCM);
    item_nxt.is_single   = (bits_r == 16'd32);
    item_nxt.left_raw    = lcap_nxt;
    item_nxt.right_raw   = rcap_nxt;
    item_valid_nxt       = accept && (fin || fv);

    // Clear captures once the frame leaves.
    if (fv) begin
      lcap_nxt = '0;
      rcap_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      shift_r <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      kind_r  <= KIND_OTHER;
      pad_r   <= 1'b0;
      tag_r   <= TAG_FLOAT;
      ch_r    <= 16'd2;
      align_r <= '0;
      bits_r  <= '0;
      idx_r   <= '0;
      lcap_r  <= '0;
      rcap_r  <= '0;
      stop_r  <= 1'b0;
      item_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        cnt_r   <= cnt_nxt;
        rem_r   <= rem_nxt;
        kind_r  <= kind_nxt;
        pad_r   <= pad_nxt;
        tag_r   <= tag_nxt;
        ch_r    <= ch_nxt;
        align_r <= align_nxt;
        bits_r  <= bits_nxt;
        idx_r   <= idx_nxt;
        lcap_r  <= lcap_nxt;
        rcap_r  <= rcap_nxt;
        stop_r  <= stop_nxt;
      end
      if (advance) item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) item_r <= item_nxt;
  end

endmodule

FILE: src/wsp_convert.sv
// Sample converter: PCM16, single and double to single, into the result register.
`timescale 1ns / 1ps
module wsp_convert (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               item_valid,
  input  wsp_pkg::wsp_item_t item,
  output logic               out_valid_r,
  output wsp_pkg::wsp_out_t  out_beat_r
);
  import wsp_pkg::*;

  function automatic logic [31:0] pcm_to_sgl(input logic [15:0] x);
    logic [15:0] mag;
    logic [3:0]  msb;
    logic [15:0] norm;
    logic [31:0] r;
    mag = x[15] ? (~x + 16'd1) : x;
    msb = '0;
    for (int k = 0; k < 16; k++) begin
      if (mag[k]) msb = 4'(k);
    end
    norm = mag << (4'd15 - msb);
    r = {x[15], 8'(8'd112 + 8'(msb)), norm[14:0], 8'd0};
    if (mag == '0) r = '0;
    return r;
  endfunction

  function automatic logic [31:0] dbl_to_sgl(input logic [63:0] d);
    logic [31:0] sgn;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig, kept, remv, half, mask;
    logic [5:0]  sh;
    logic [31:0] r;
    sgn  = {d[63], 31'd0};
    e    = d[62:52];
    m    = d[51:0];
    sig  = {1'b1, m};
    sh   = (e >= 11'd897) ? 6'd29 : 6'(11'd926 - e);
    kept = sig >> sh;
    mask = (53'd1 << sh) - 53'd1;
    remv = sig & mask;
    half = 53'd1 << (sh - 6'd1);
    if ((remv > half) || ((remv == half) && kept[0])) kept = kept + 53'd1;
    if (e == 11'h7FF) begin
      if (m == '0) r = sgn | 32'h7F80_0000;
      else r = sgn | 32'h7FC0_0000 | {10'd0, m[50:29]};
    end else if ((e == '0) || (e < 11'd873)) begin
      r = sgn;
    end else if (e >= 11'd1151) begin
      r = sgn | 32'h7F80_0000;
    end else if (e >= 11'd897) begin
      r = sgn | ((32'(e - 11'd897) << 23) + kept[31:0]);
    end else begin
      r = sgn | kept[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] conv(input logic [63:0] raw, input logic pcm,
                                       input logic sgl);
    logic [31:0] r;
    if (pcm) r = pcm_to_sgl(raw[15:0]);
    else if (sgl) r = raw[31:0];
    else r = dbl_to_sgl(raw);
    return r;
  endfunction

  wsp_out_t out_nxt;

  always_comb begin
    out_nxt.frame_valid  = item.frame_valid;
    out_nxt.status       = item.status;
    out_nxt.finished     = item.finished;
    out_nxt.left_sample  = '0;
    out_nxt.right_sample = '0;
    if (item.frame_valid) begin
      out_nxt.left_sample  = conv(item.left_raw, item.is_pcm, item.is_single);
      out_nxt.right_sample = conv(item.right_raw, item.is_pcm, item.is_single);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (advance) out_valid_r <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) out_beat_r <= out_nxt;
  end

endmodule

FILE: src/wav_stream_parser_stereo.sv
// Top level: byte-serial WAVE parser delivering stereo single-precision frames.
// A byte's result beat is registered in the parser item register, then in the result register.
// Throughput: one byte per cycle while advancing; the pipeline advances whenever the result
// register is empty or being taken, so in_stall depends only on out_valid and out_stall.
// Reset: synchronous active-low rst_n returns to expecting the RIFF id with
// float/stereo defaults; after a finished beat all later bytes are dropped.
`timescale 1ns / 1ps
module wav_stream_parser_stereo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wsp_pkg::wsp_in_t  in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output wsp_pkg::wsp_out_t out_beat
);
  import wsp_pkg::*;

  logic      advance;
  logic      item_valid;
  wsp_item_t item;

  // Advance both stages together whenever the result slot frees up.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Stage one: parse the byte, update chunk state, capture raw frame bytes.
  wsp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .in_valid     (in_valid),
    .in_beat      (in_beat),
    .item_valid_r (item_valid),
    .item_r       (item)
  );

  // Stage two: turn raw samples into single-precision words and hold the beat.
  wsp_convert u_convert (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item_valid  (item_valid),
    .item        (item),
    .out_valid_r (out_valid),
    .out_beat_r  (out_beat)
  );

endmodule

FILE: tb/tb_wav_stream_parser_stereo.sv
// Testbench: streams one random WAVE file through the parser and scores every result beat.
`timescale 1ns / 1ps
module tb_wav_stream_parser_stereo;
  import wsp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Parser phases of the predictor, in stream order.
  typedef enum logic [3:0] {
    PH_RIFF, PH_FSIZE, PH_WAVE, PH_CKID, PH_CKSIZE, PH_FMT, PH_SKIP, PH_DATA
  } parse_phase_e;

  // Predicts the frames of a byte stream and matches them against the result beats.
  class frame_scoreboard;
    parse_phase_e phase;
    logic [31:0]  shift_word;
    logic [2:0]   field_cnt;
    logic [31:0]  remain;
    logic [1:0]   kind;
    logic         pad_pending;
    logic [15:0]  tag, chans, align, bits, fidx;
    logic [63:0]  lcap, rcap;
    logic         stopped;
    wsp_out_t     frame_q[$];
    int           errors;

    function new();
      phase = PH_RIFF;
      shift_word = '0;
      field_cnt = '0;
      remain = '0;
      kind = KIND_OTHER;
      pad_pending = 1'b0;
      tag = TAG_FLOAT;
      chans = 16'd2;
      align = '0;
      bits = '0;
      fidx = '0;
      lcap = '0;
      rcap = '0;
      stopped = 1'b0;
      errors = 0;
    endfunction

    // 16-bit PCM times 2^-15 is always exact in single precision.
    function logic [31:0] pcm_word(logic [15:0] r);
      logic [15:0] mag;
      logic [31:0] mant;
      int p;
      if (r == 16'd0) return 32'd0;
      mag = r[15] ? (~r + 16'd1) : r;
      p = 0;
      for (int k = 0; k < 16; k++) if (mag[k]) p = k;
      mant = 32'(mag) << (23 - p);
      return {r[15], 8'(p + 112), mant[22:0]};
    endfunction

    // Double to single, round to nearest even.
    function logic [31:0] dbl_word(logic [63:0] d);
      logic [31:0] sgn;
      longint unsigned e, m, sig, kept, rem, half, sh;
      sgn = {d[63], 31'd0};
      e = longint'(d[62:52]);
      m = longint'(d[51:0]);
      if (e == 2047) begin
        if (m == 0) return sgn | 32'h7F80_0000;
        return sgn | 32'h7FC0_0000 | {10'd0, d[50:29]};
      end
      if (e == 0 || e + 53 < 926) return sgn;
      if (e >= 1151) return sgn | 32'h7F80_0000;
      sig = m | (64'd1 << 52);
      sh = (e >= 897) ? 29 : 926 - e;
      kept = sig >> sh;
      rem = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
      if (e >= 897) return sgn | 32'(((e - 897) << 23) + kept);
      return sgn | 32'(kept);
    endfunction

    function logic [31:0] convert(logic [63:0] raw);
      if (tag == TAG_PCM) return pcm_word(raw[15:0]);
      if (bits == 16'd32) return raw[31:0];
      return dbl_word(raw);
    endfunction

    function void enter_skip(logic [31:0] count, logic pad);
      remain = count;
      pad_pending = pad;
      phase = (count == 0 && !pad) ? PH_CKID : PH_SKIP;
    endfunction

    // Advance the predictor by one accepted byte.
    function void note_byte(wsp_in_t beat);
      logic [7:0]  b;
      logic        fin, fv, done;
      logic [2:0]  st;
      logic [31:0] lw, rw, prod, bps, lidx, ridx, loff, roff, i;
      wsp_out_t    res;
      b = beat.data_byte;
      fin = 1'b0; fv = 1'b0; done = 1'b0; st = ST_OK; lw = '0; rw = '0;
      if (stopped) return;
      if (phase <= PH_CKSIZE) begin
        shift_word = {b, shift_word[31:8]};
        field_cnt = field_cnt + 3'd1;
        if (field_cnt >= 3'd4) begin
          field_cnt = '0;
          done = 1'b1;
        end
      end
      case (phase)
        PH_RIFF: if (done) begin
          if (shift_word != ID_RIFF) begin fin = 1'b1; st = ST_NOT_RIFF; end
          else phase = PH_FSIZE;
        end
        PH_FSIZE: if (done) phase = PH_WAVE;
        PH_WAVE: if (done) begin
          if (shift_word != ID_WAVE) begin fin = 1'b1; st = ST_NOT_WAVE; end
          else phase = PH_CKID;
        end
        PH_CKID: if (done) begin
          kind = (shift_word == ID_FMT) ? KIND_FMT :
                 (shift_word == ID_DATA) ? KIND_DATA : KIND_OTHER;
          phase = PH_CKSIZE;
        end
        PH_CKSIZE: if (done) begin
          remain = shift_word;
          if (kind == KIND_FMT) begin
            fidx = '0;
            phase = PH_FMT;
          end else if (kind == KIND_DATA) begin
            if (tag == TAG_PCM) st = (bits == 16'd16) ? ST_OK : ST_BITS;
            else if (tag == TAG_FLOAT)
              st = (bits == 16'd32 || bits == 16'd64) ? ST_OK : ST_BITS;
            else st = ST_COMPRESS;
            if (st != ST_OK || remain == 0) fin = 1'b1;
            else begin
              fidx = '0; lcap = '0; rcap = '0;
              phase = PH_DATA;
            end
          end else begin
            enter_skip(shift_word, shift_word[0]);
          end
        end
        PH_FMT: begin
          case (fidx)
            16'd0:  tag = {8'd0, b};
            16'd1:  tag[15:8] = b;
            16'd2:  chans = {8'd0, b};
            16'd3:  chans[15:8] = b;
            16'd12: align = {8'd0, b};
            16'd13: align[15:8] = b;
            16'd14: bits = {8'd0, b};
            16'd15: bits[15:8] = b;
            default: ;
          endcase
          fidx = fidx + 16'd1;
          if (fidx >= 16'd16) begin
            fidx = '0;
            prod = 32'(chans) * 32'(bits >> 3);
            if (32'(align) != prod) st = ST_ALIGN;
            else if (tag != TAG_PCM && tag != TAG_FLOAT) st = ST_COMPRESS;
            else if (chans == 0 || chans == 5 || chans > 6) st = ST_CHANNELS;
            if (st != ST_OK) fin = 1'b1;
            else if (remain > 16) enter_skip(remain - 16, remain[0]);
            else enter_skip(0, 1'b0);
          end
        end
        PH_SKIP: begin
          if (remain > 0) remain--;
          else pad_pending = 1'b0;
          if (remain == 0 && !pad_pending) phase = PH_CKID;
        end
        PH_DATA: begin
          bps = 32'(bits[6:3]);
          case (chans)
            16'd1: begin lidx = 0; ridx = 0; end
            16'd4: begin lidx = 0; ridx = 2; end
            16'd6: begin lidx = 1; ridx = 4; end
            default: begin lidx = 0; ridx = 1; end
          endcase
          loff = lidx * bps;
          roff = ridx * bps;
          i = 32'(fidx);
          if (i >= loff && i < loff + bps && i - loff < 8)
            lcap = lcap | (64'(b) << (8 * (i - loff)));
          if (i >= roff && i < roff + bps && i - roff < 8)
            rcap = rcap | (64'(b) << (8 * (i - roff)));
          fidx = fidx + 16'd1;
          remain--;
          if (fidx >= align) begin
            fv = 1'b1;
            lw = convert(lcap);
            rw = convert(rcap);
            fidx = '0; lcap = '0; rcap = '0;
          end
          if (remain == 0) fin = 1'b1;
        end
        default: begin fin = 1'b1; st = ST_EOF; end
      endcase
      if (!fin && beat.end_of_file) begin
        fin = 1'b1;
        st = ST_EOF;
      end
      if (fin) stopped = 1'b1;
      if (!fin && !fv) return;
      res.left_sample = lw;
      res.right_sample = rw;
      res.frame_valid = fv;
      res.status = st;
      res.finished = fin;
      frame_q.push_back(res);
    endfunction

    // Compare one result beat with the oldest predicted frame.
    function void check_beat(wsp_out_t got);
      wsp_out_t exp_b;
      if (frame_q.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      exp_b = frame_q.pop_front();
      if (got.left_sample !== exp_b.left_sample) begin
        $error("left_sample exp %h got %h", exp_b.left_sample, got.left_sample);
        errors++;
      end
      if (got.right_sample !== exp_b.right_sample) begin
        $error("right_sample exp %h got %h", exp_b.right_sample, got.right_sample);
        errors++;
      end
      if (got.frame_valid !== exp_b.frame_valid) begin
        $error("frame_valid exp %b got %b", exp_b.frame_valid, got.frame_valid);
        errors++;
      end
      if (got.status !== exp_b.status) begin
        $error("status exp %0d got %0d", exp_b.status, got.status);
        errors++;
      end
      if (got.finished !== exp_b.finished) begin
        $error("finished exp %b got %b", exp_b.finished, got.finished);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  wsp_in_t  in_beat = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  wsp_out_t out_beat;

  frame_scoreboard sb = new();
  wsp_in_t  file_q[$];
  int       next_idx = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_mode = 0;
  int       stall_run = 0;
  int       cycles = 0;

  always #2 clk = ~clk;

  wav_stream_parser_stereo u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  task automatic put_byte(logic [7:0] b, logic eof = 1'b0);
    wsp_in_t t;
    t.data_byte = b;
    t.end_of_file = eof;
    file_q.push_back(t);
  endtask

  task automatic put_word(logic [31:0] w, int n = 4);
    for (int k = 0; k < n; k++) put_byte(w[8*k +: 8]);
  endtask

  // Emit a 16-byte fmt body; the unchecked rate fields get random content.
  task automatic put_fmt_body(logic [15:0] ftag, logic [15:0] ch, logic [15:0] bw);
    put_word(32'(ftag), 2);
    put_word(32'(ch), 2);
    put_word($urandom());
    put_word($urandom());
    put_word(32'(ch * (bw >> 3)), 2);
    put_word(32'(bw), 2);
  endtask

  // Pick a sample: corner values for the first frames, then mostly random.
  function automatic logic [63:0] pick_sample(int k, logic [15:0] bw);
    logic [63:0] v;
    int mode;
    v = {$urandom(), $urandom()};
    mode = $urandom_range(0, 9);
    if (k >= 10 && mode < 3) k = $urandom_range(0, 9);
    if (bw == 16'd16) begin
      case (k)
        0: v = 64'h0000; 1: v = 64'h7FFF; 2: v = 64'h8000; 3: v = 64'hFFFF;
        4: v = 64'h0001; 5: v = 64'h4000; default: ;
      endcase
    end else if (bw == 16'd32) begin
      case (k)
        0: v = 64'h0; 1: v = 64'h8000_0000; 2: v = 64'h7F80_0000;
        3: v = 64'h7FC0_0001; 4: v = 64'h1; 5: v = 64'hFFFF_FFFF;
        default: ;
      endcase
    end else begin
      case (k)
        0: v = 64'h0;
        1: v = 64'h8000_0000_0000_0000;
        2: v = 64'h7FF0_0000_0000_0000;
        3: v = 64'hFFF8_0000_2000_0123;
        4: v = 64'h0000_0000_0000_0001;
        5: v = 64'h7FEF_FFFF_FFFF_FFFF;
        6: v = 64'h36A0_0000_0000_0000;
        7: v = 64'hB690_0000_0000_0000;
        8: v = 64'h47EF_FFFF_F000_0000;
        9: v = 64'h3810_0000_1000_0000;
        default: if (mode < 8) v[62:52] = 11'($urandom_range(860, 1160));
      endcase
    end
    return v;
  endfunction

  // Build the whole file: header, odd and empty chunks, a short fmt, the real
  // fmt with extra bytes, then the data chunk ending cleanly or truncated.
  task automatic build_file();
    logic [15:0] ftag, ch, bw, fb;
    logic [31:0] dsize;
    logic [63:0] smp;
    int nf, extra, partial, trunc, sel;
    sel = $urandom_range(0, 2);
    bw = (sel == 0) ? 16'd16 : (sel == 1) ? 16'd32 : 16'd64;
    ftag = (sel == 0) ? TAG_PCM : TAG_FLOAT;
    case ($urandom_range(0, 4))
      0: ch = 16'd1; 1: ch = 16'd2; 2: ch = 16'd3; 3: ch = 16'd4; default: ch = 16'd6;
    endcase
    fb = ch * (bw >> 3);
    put_word(ID_RIFF);
    put_word($urandom());
    put_word(ID_WAVE);
    put_word(32'h5453_494C);
    put_word(32'd3);
    repeat (4) put_byte(8'($urandom()));
    put_word(32'h6B6E_756A);
    put_word(32'd0);
    // Short fmt chunk: all 16 field bytes are read despite the size of 14.
    put_word(ID_FMT);
    put_word(32'd14);
    put_fmt_body(TAG_PCM, 16'd2, 16'd16);
    extra = $urandom_range(0, 5);
    put_word(ID_FMT);
    put_word(32'(16 + extra));
    put_fmt_body(ftag, ch, bw);
    repeat (extra + (extra % 2)) put_byte(8'($urandom()));
    nf = 1500 / fb;
    partial = $urandom_range(0, fb - 1);
    trunc = $urandom_range(0, 1);
    dsize = 32'(nf * fb + partial) + (trunc ? 32'd64 : 32'd0);
    put_word(ID_DATA);
    put_word(dsize);
    for (int f = 0; f < nf; f++) begin
      for (int c = 0; c < ch; c++) begin
        smp = pick_sample(f, bw);
        for (int k = 0; k < bw / 8; k++) put_byte(smp[8*k +: 8]);
      end
    end
    repeat (partial) put_byte(8'($urandom()));
    if (trunc) begin
      put_byte(8'($urandom()), 1'b1);
    end else begin
      // Drop-through bytes after the end, with random final-byte flags.
      repeat (40) put_byte(8'($urandom()), 1'($urandom()));
    end
  endtask

  // Sender: bursts of random length with random gaps; hold a stalled beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_byte(in_beat);
        next_idx++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (next_idx < file_q.size()) begin
          in_valid <= 1'b1;
          in_beat <= file_q[next_idx];
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch among no stall, random stall and a periodic pattern.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(10, 120);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (stall_run % 4 == 0);
    endcase
  end

  // Monitor: score every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_beat);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL wav_stream_parser_stereo");
      $finish;
    end
  end

  initial begin
    build_file();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (next_idx < file_q.size()) @(posedge clk);
    while (sb.frame_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.frame_q.size() != 0) begin
      $error("%0d predicted frames never arrived", sb.frame_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS wav_stream_parser_stereo");
    end else begin
      $display("FAIL wav_stream_parser_stereo");
    end
    $finish;
  end
endmodule
